// ----- src/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

    localparam logic [20:0] REPL_CP       = 21'h00FFFD;
    localparam logic [20:0] SUPPLEMENT_CP = 21'h010000;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;

    // Allowed range of a continuation byte, and the narrowed second-byte bounds.
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;

    localparam logic [2:0] REPL_LEN  = 3'd3;

    typedef struct packed {
        logic [20:0] partial_value;
        logic [1:0]  bytes_remaining;
        logic [2:0]  bytes_seen;
        logic [7:0]  next_low_bound;
        logic [7:0]  next_high_bound;
    } t_state;

    localparam t_state IDLE_STATE = '{
        partial_value:   21'd0,
        bytes_remaining: 2'd0,
        bytes_seen:      3'd0,
        next_low_bound:  CONT_LO,
        next_high_bound: CONT_HI
    };

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic [2:0]  units_consumed;
        logic [2:0]  utf8_length;
        logic [15:0] utf16_first;
        logic [15:0] utf16_second;
        logic [1:0]  utf16_count;
        logic        last_of_run;
    } t_result;

    // Builds one result with its UTF-8 length and UTF-16 form.
    function automatic t_result make_result(input logic [20:0] cp, input logic repl,
                                            input logic [2:0] units);
        logic [20:0] ofs;
        t_result     r;
        ofs              = cp - SUPPLEMENT_CP;
        r.code_point     = cp;
        r.replaced       = repl;
        r.units_consumed = units;
        if (repl) begin
            r.utf8_length = REPL_LEN;
        end else if (cp <= 21'h00007F) begin
            r.utf8_length = 3'd1;
        end else if (cp <= 21'h0007FF) begin
            r.utf8_length = 3'd2;
        end else if (cp <= 21'h00FFFF) begin
            r.utf8_length = 3'd3;
        end else begin
            r.utf8_length = 3'd4;
        end
        if (cp <= 21'h00FFFF) begin
            r.utf16_first  = cp[15:0];
            r.utf16_second = 16'd0;
            r.utf16_count  = 2'd1;
        end else begin
            r.utf16_first  = HIGH_SURR + {6'd0, ofs[19:10]};
            r.utf16_second = LOW_SURR + {6'd0, ofs[9:0]};
            r.utf16_count  = 2'd2;
        end
        r.last_of_run = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/utf8_validating_decoder.sv -----
`default_nettype none

// Channel   Direction  Data                       Side band
// s_axis    in         tdata: in_byte [7:0]       tlast: end_of_input
// m_axis    out        tdata: see port comment    tuser: replaced, tlast: last_of_run
//
// One byte is taken per cycle while s_axis_tready stays high. A byte lands in
// an input register, is decoded by the step logic and its results go into a
// two-slot result register, from which they are offered on m_axis. The output
// port moves one result per cycle while m_axis_tready is high; while a byte's
// two results are queued, a following byte with results waits. Reset
// (synchronous, active low) returns the decoder to the no-sequence state and
// empties both registers. A stall on the output side fills the result register
// and then the input register before s_axis_tready falls; nothing is dropped.
module utf8_validating_decoder
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte [7:0]
    input  wire logic        s_axis_tlast,   // end_of_input

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // code_point [20:0], units_consumed [23:21], utf8_length [26:24],
    // utf16_first [42:27], utf16_second [58:43], utf16_count [60:59], zero [63:61]
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // replaced
    output logic             m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    logic [1:0] r_out_cnt;
    t_result    r_out0;
    t_result    r_out1;

    t_state     step_next;
    logic [1:0] step_count;
    t_result    step_res0;
    t_result    step_res1;
    logic       out_free;
    logic       consume;

    utf8d_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_last),
        .o_next  (step_next),
        .o_count (step_count),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    // The result register can take new results when it is empty or its only
    // result leaves in this cycle. A byte with no result never waits.
    assign out_free      = (r_out_cnt == 2'd0) || (r_out_cnt == 2'd1 && m_axis_tready);
    assign consume       = r_in_valid && (step_count == 2'd0 || out_free);
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE_STATE;
        end else if (consume) begin
            r_state <= step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (consume && step_count != 2'd0) begin
            r_out_cnt <= step_count;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_out_cnt <= (r_out_cnt == 2'd2) ? 2'd1 : 2'd0;
        end
        if (consume && step_count != 2'd0) begin
            r_out0 <= step_res0;
            r_out1 <= step_res1;
        end else if (m_axis_tvalid && m_axis_tready && r_out_cnt == 2'd2) begin
            r_out0 <= r_out1;
        end
    end

    assign m_axis_tvalid = (r_out_cnt != 2'd0);
    assign m_axis_tdata  = {3'd0, r_out0.utf16_count, r_out0.utf16_second,
                            r_out0.utf16_first, r_out0.utf8_length,
                            r_out0.units_consumed, r_out0.code_point};
    assign m_axis_tuser  = r_out0.replaced;
    assign m_axis_tlast  = r_out0.last_of_run;

    // The first of two queued results never closes its byte's run.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt == 2'd2 |-> !r_out0.last_of_run)
        else $error("first of two results marked last_of_run");

    // A pending sequence always has its lead byte counted.
    a_seen_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_remaining != 2'd0 |-> r_state.bytes_seen != 3'd0)
        else $error("pending sequence without lead byte");

    // Results of a decoded byte all land in the result register.
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && step_count != 2'd0 |=> r_out_cnt == $past(step_count))
        else $error("result register count mismatch after load");

    // A held byte stays put until it is decoded.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost or changed");

endmodule

`default_nettype wire

// ----- src/utf8d_step.sv -----
`default_nettype none

// Decode of one byte against the current sequence state: next state and up
// to two results, in order.
module utf8d_step
    import utf8d_pkg::*;
(
    input  wire t_state      i_state,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_eoi,
    output t_state           o_next,
    output logic [1:0]       o_count,
    output t_result          o_res0,
    output t_result          o_res1
);

    t_result     res [2];
    logic [1:0]  cnt;
    t_state      nxt;
    logic        in_range;
    logic [20:0] grown;
    logic [1:0]  rem_dec;

    always_comb begin
        in_range = (i_byte >= i_state.next_low_bound) && (i_byte <= i_state.next_high_bound);
        grown    = {i_state.partial_value[14:0], i_byte[5:0]};
        rem_dec  = i_state.bytes_remaining - 2'd1;
        res[0]   = make_result(REPL_CP, 1'b1, 3'd1);
        res[1]   = make_result(REPL_CP, 1'b1, 3'd1);
        cnt      = 2'd0;
        nxt      = i_state;

        if (i_state.bytes_remaining != 2'd0 && in_range) begin
            nxt.partial_value   = grown;
            nxt.bytes_seen      = i_state.bytes_seen + 3'd1;
            nxt.bytes_remaining = rem_dec;
            nxt.next_low_bound  = CONT_LO;
            nxt.next_high_bound = CONT_HI;
            if (rem_dec == 2'd0) begin
                res[0] = make_result(grown, 1'b0, i_state.bytes_seen + 3'd1);
                cnt    = 2'd1;
                nxt    = IDLE_STATE;
            end
        end else begin
            // A broken sequence is closed first; the byte then starts afresh.
            if (i_state.bytes_remaining != 2'd0) begin
                res[0]             = make_result(REPL_CP, 1'b1, i_state.bytes_seen);
                res[0].last_of_run = 1'b0;
                cnt                = 2'd1;
            end
            nxt = IDLE_STATE;
            if (i_byte <= 8'h7F) begin
                res[cnt[0]] = make_result({13'd0, i_byte}, 1'b0, 3'd1);
                cnt         = cnt + 2'd1;
            end else if (i_byte inside {[8'hC2:8'hDF]}) begin
                nxt.partial_value   = {16'd0, i_byte[4:0]};
                nxt.bytes_remaining = 2'd1;
                nxt.bytes_seen      = 3'd1;
            end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                nxt.partial_value   = {17'd0, i_byte[3:0]};
                nxt.bytes_remaining = 2'd2;
                nxt.bytes_seen      = 3'd1;
                nxt.next_low_bound  = (i_byte == LEAD_E0) ? E0_LO : CONT_LO;
                nxt.next_high_bound = (i_byte == LEAD_ED) ? ED_HI : CONT_HI;
            end else if (i_byte inside {[8'hF0:8'hF4]}) begin
                nxt.partial_value   = {18'd0, i_byte[2:0]};
                nxt.bytes_remaining = 2'd3;
                nxt.bytes_seen      = 3'd1;
                nxt.next_low_bound  = (i_byte == LEAD_F0) ? F0_LO : CONT_LO;
                nxt.next_high_bound = (i_byte == LEAD_F4) ? F4_HI : CONT_HI;
            end else begin
                res[cnt[0]] = make_result(REPL_CP, 1'b1, 3'd1);
                cnt         = cnt + 2'd1;
            end
        end

        // A sequence cut off by the end of the buffer is replaced as a whole.
        if (i_eoi && nxt.bytes_remaining != 2'd0) begin
            if (cnt != 2'd0) begin
                res[0].last_of_run = 1'b0;
            end
            res[cnt[0]] = make_result(REPL_CP, 1'b1, nxt.bytes_seen);
            cnt         = cnt + 2'd1;
        end
        if (i_eoi) begin
            nxt = IDLE_STATE;
        end

        o_next  = nxt;
        o_count = cnt;
        o_res0  = res[0];
        o_res1  = res[1];
    end

endmodule

`default_nettype wire

// ----- verif/utf8_decode_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels of the UTF-8 decoder. Every byte transfer on
// the input side is decoded by a local model into the scalars it should
// produce; every result transfer on the output side is compared with the
// oldest scalar still due.
module utf8_decode_checker
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_out_data,
    input  wire logic        i_out_user,
    input  wire logic        i_out_last,

    output logic [31:0]      o_mismatches,
    output logic [31:0]      o_pending,
    output logic [31:0]      o_results,
    output logic [31:0]      o_replacements,
    output logic [31:0]      o_pairs
);

    // Lead byte ranges that open a two, three or four byte sequence.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] ASCII_MAX = 8'h7F;

    // Decoder state kept by the model.
    logic [20:0] acc_value;
    logic [1:0]  cont_left;
    logic [2:0]  seq_bytes;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;

    t_result     due_scalars [$];
    t_result     step_out [2];
    int          step_n;
    t_result     want;

    int mismatches   = 0;
    int results      = 0;
    int replacements = 0;
    int pairs        = 0;

    assign o_mismatches   = mismatches;
    assign o_pending      = due_scalars.size();
    assign o_results      = results;
    assign o_replacements = replacements;
    assign o_pairs        = pairs;

    function automatic t_result scalar_result(input logic [20:0] cp, input logic repl,
                                              input logic [2:0] units);
        t_result     r;
        logic [20:0] ofs;
        ofs              = cp - SUPPLEMENT_CP;
        r                = '0;
        r.code_point     = cp;
        r.replaced       = repl;
        r.units_consumed = units;
        r.last_of_run    = 1'b1;
        if (repl) begin
            r.utf8_length = REPL_LEN;
        end else if (cp < 21'h80) begin
            r.utf8_length = 3'd1;
        end else if (cp < 21'h800) begin
            r.utf8_length = 3'd2;
        end else if (cp < SUPPLEMENT_CP) begin
            r.utf8_length = 3'd3;
        end else begin
            r.utf8_length = 3'd4;
        end
        if (cp < SUPPLEMENT_CP) begin
            r.utf16_first = cp[15:0];
            r.utf16_count = 2'd1;
        end else begin
            r.utf16_first  = HIGH_SURR | {6'd0, ofs[19:10]};
            r.utf16_second = LOW_SURR | {6'd0, ofs[9:0]};
            r.utf16_count  = 2'd2;
        end
        return r;
    endfunction

    task automatic clear_seq();
        acc_value = '0;
        cont_left = '0;
        seq_bytes = '0;
        cont_lo   = CONT_LO;
        cont_hi   = CONT_HI;
    endtask

    task automatic note(input t_result r);
        step_out[step_n] = r;
        step_n++;
    endtask

    // A byte seen with no sequence open: either a complete scalar, a bad
    // lead, or the start of a multi-byte sequence.
    task automatic take_lead(input logic [7:0] b);
        if (b <= ASCII_MAX) begin
            note(scalar_result({13'd0, b}, 1'b0, 3'd1));
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            acc_value = {16'd0, b[4:0]};
            cont_left = 2'd1;
            seq_bytes = 3'd1;
        end else if (b >= LEAD_E0 && b <= LEAD3_MAX) begin
            acc_value = {17'd0, b[3:0]};
            cont_left = 2'd2;
            seq_bytes = 3'd1;
            if (b == LEAD_E0) cont_lo = E0_LO;
            if (b == LEAD_ED) cont_hi = ED_HI;
        end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
            acc_value = {18'd0, b[2:0]};
            cont_left = 2'd3;
            seq_bytes = 3'd1;
            if (b == LEAD_F0) cont_lo = F0_LO;
            if (b == LEAD_F4) cont_hi = F4_HI;
        end else begin
            note(scalar_result(REPL_CP, 1'b1, 3'd1));
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eoi);
        step_n = 0;
        if (cont_left != 0) begin
            if (b >= cont_lo && b <= cont_hi) begin
                acc_value = {acc_value[14:0], b[5:0]};
                seq_bytes = seq_bytes + 3'd1;
                cont_left = cont_left - 2'd1;
                cont_lo   = CONT_LO;
                cont_hi   = CONT_HI;
                if (cont_left == 0) begin
                    note(scalar_result(acc_value, 1'b0, seq_bytes));
                    clear_seq();
                end
            end else begin
                // The breaking byte closes the subpart and then starts over.
                note(scalar_result(REPL_CP, 1'b1, seq_bytes));
                step_out[step_n - 1].last_of_run = 1'b0;
                clear_seq();
                take_lead(b);
            end
        end else begin
            take_lead(b);
        end
        if (eoi && cont_left != 0) begin
            if (step_n > 0) step_out[step_n - 1].last_of_run = 1'b0;
            note(scalar_result(REPL_CP, 1'b1, seq_bytes));
        end
        if (eoi) clear_seq();
        for (int i = 0; i < step_n; i++) due_scalars.push_back(step_out[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_scalars.delete();
            clear_seq();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_scalars.size() == 0) begin
                    $error("result 0x%0h arrived with nothing due", i_out_data[20:0]);
                    mismatches++;
                end else begin
                    want = due_scalars.pop_front();
                    compare_field("code_point", 32'(want.code_point),
                                  32'(i_out_data[20:0]));
                    compare_field("units_consumed", 32'(want.units_consumed),
                                  32'(i_out_data[23:21]));
                    compare_field("utf8_length", 32'(want.utf8_length),
                                  32'(i_out_data[26:24]));
                    compare_field("utf16_first", 32'(want.utf16_first),
                                  32'(i_out_data[42:27]));
                    compare_field("utf16_second", 32'(want.utf16_second),
                                  32'(i_out_data[58:43]));
                    compare_field("utf16_count", 32'(want.utf16_count),
                                  32'(i_out_data[60:59]));
                    compare_field("tdata padding", 32'd0, 32'(i_out_data[63:61]));
                    compare_field("replaced", 32'(want.replaced), 32'(i_out_user));
                    compare_field("last_of_run", 32'(want.last_of_run), 32'(i_out_last));
                end
                results++;
                if (i_out_user) replacements++;
                if (i_out_data[60:59] == 2'd2) pairs++;
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_byte, i_in_last);
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

// Top of the decoder bench. It only makes traffic: a directed byte list,
// then random UTF-8 text mixed with truncated sequences, out-of-range second
// bytes and raw noise, over four idling phases. All checking happens in the
// checker, which hands back its mismatch count for the verdict.
module tb_top;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 132;
    localparam int DRAIN_CYCLES  = 8;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // in_byte [7:0]
    logic        s_axis_tlast  = 1'b0;   // end_of_input

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // code_point [20:0], units_consumed [23:21], utf8_length [26:24],
    // utf16_first [42:27], utf16_second [58:43], utf16_count [60:59], zero [63:61]
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;           // replaced
    logic        m_axis_tlast;           // last_of_run

    logic [31:0] mismatches;
    logic [31:0] pending;
    logic [31:0] results;
    logic [31:0] replacements;
    logic [31:0] pairs;

    // Idling knobs in percent, changed per phase by the stimulus process.
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_req     = 1'b0;
    int          bytes_sent   = 0;
    int          cycle_count  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    utf8_validating_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_user     (m_axis_tuser),
        .i_out_last     (m_axis_tlast),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results),
        .o_replacements (replacements),
        .o_pairs        (pairs)
    );

    // Offers one byte, optionally after a random gap, and returns at the
    // edge where the transfer takes place. All sampling happens right at the
    // rising edge, so the values seen are the ones from before that edge.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Encodes a scalar as UTF-8 and sends at most its first keep bytes; the
    // end-of-input flag, if asked for, rides on the last byte sent.
    task automatic send_scalar(input logic [20:0] cp, input int keep, input logic eoi);
        logic [7:0] u [4];
        int         n;
        int         k;
        if (cp < 21'h80) begin
            u[0] = cp[7:0];
            n    = 1;
        end else if (cp < 21'h800) begin
            u[0] = {3'b110, cp[10:6]};
            u[1] = {2'b10, cp[5:0]};
            n    = 2;
        end else if (cp < 21'h10000) begin
            u[0] = {4'b1110, cp[15:12]};
            u[1] = {2'b10, cp[11:6]};
            u[2] = {2'b10, cp[5:0]};
            n    = 3;
        end else begin
            u[0] = {5'b11110, cp[20:18]};
            u[1] = {2'b10, cp[17:12]};
            u[2] = {2'b10, cp[11:6]};
            u[3] = {2'b10, cp[5:0]};
            n    = 4;
        end
        k = (keep < n) ? keep : n;
        for (int i = 0; i < k; i++) send_byte(u[i], eoi && (i == k - 1));
    endtask

    // Random scalar value of a random encoded length. A quarter of the picks
    // land on the ends of the length class, and surrogates are moved to the
    // nearest scalar on either side of the gap.
    function automatic logic [20:0] pick_scalar();
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case ($urandom_range(3))
            0: begin lo = 21'h0;     hi = 21'h7F;     end
            1: begin lo = 21'h80;    hi = 21'h7FF;    end
            2: begin lo = 21'h800;   hi = 21'hFFFF;   end
            default: begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        if ($urandom_range(3) == 0) begin
            cp = $urandom_range(1) ? lo : hi;
        end else begin
            cp = 21'($urandom_range(hi, lo));
        end
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = $urandom_range(1) ? 21'hD7FF : 21'hE000;
        return cp;
    endfunction

    // Receiver: random stalls by phase, plus one long hold-off on request.
    // The hold is counted here so the sender keeps offering bytes until the
    // decoder fills up and drops s_axis_tready.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: a run that hangs is a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [20:0] cp;
        logic [7:0]  lead;
        logic [7:0]  second;
        int          len;
        int          kind;
        int          stop_at;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            // Phases: no idling, sender gaps, receiver stalls, then both.
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 54; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 54; end
                default: begin send_gap_pct = 21; stall_pct = 21; end
            endcase

            if (phase == 0) begin
                // ASCII extremes, U+0080 and the top scalar U+10FFFF.
                send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
                send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
                send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
                send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
                // Narrowed second bytes just outside their range: each breaks
                // the sequence and is then rejected as a lead, two results.
                send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0);
                send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
                send_byte(8'hF0, 1'b0); send_byte(8'h8F, 1'b0);
                send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
                // Bad leads, and a sequence broken by plain ASCII.
                send_byte(8'hFF, 1'b0); send_byte(8'hC1, 1'b0);
                send_byte(8'hE1, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
                // Buffer ends inside a sequence.
                send_byte(8'hF1, 1'b0); send_byte(8'h80, 1'b1);
                // Break by a new lead that is itself cut off by the end flag.
                send_byte(8'hE1, 1'b0); send_byte(8'hC3, 1'b1);
                hold_req = 1'b1;
            end

            stop_at = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at) begin
                kind = $urandom_range(99);
                if (kind < 55) begin
                    // Well-formed scalar, now and then ending the buffer.
                    send_scalar(pick_scalar(), 4, $urandom_range(15) == 0);
                end else if (kind < 80) begin
                    // Truncated multi-byte sequence, broken either by the
                    // next item or by the end flag on its last byte.
                    cp  = pick_scalar() | 21'h80;
                    len = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
                    send_scalar(cp, $urandom_range(len - 1, 1), kind >= 70);
                end else if (kind < 88) begin
                    // Lead with a narrowed range and a second byte outside it.
                    case ($urandom_range(3))
                        0: begin lead = 8'hE0; second = 8'($urandom_range(8'h9F, 8'h80)); end
                        1: begin lead = 8'hED; second = 8'($urandom_range(8'hBF, 8'hA0)); end
                        2: begin lead = 8'hF0; second = 8'($urandom_range(8'h8F, 8'h80)); end
                        default: begin
                            lead   = 8'hF4;
                            second = 8'($urandom_range(8'hBF, 8'h90));
                        end
                    endcase
                    send_byte(lead, 1'b0);
                    send_byte(second, 1'b0);
                end else begin
                    send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait until every predicted result has been seen, then keep the
        // clock running so that any stray transfer shows.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes over four idling phases with one long output hold-off.",
                 bytes_sent);
        $display("Checked %0d results: %0d replacements, %0d surrogate pairs.",
                 results, replacements, pairs);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
